>>> hdl/arhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arhp_pkg
// Shared types, codes and constants of the ar archive header parser.
// ----------------------------------------------------------------------------
package arhp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error causes.
    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_MAGIC     = 3'd1;
    localparam logic [2:0] CAUSE_SHORT     = 3'd2;
    localparam logic [2:0] CAUSE_NO_SLASH  = 3'd3;
    localparam logic [2:0] CAUSE_BAD_DIGIT = 3'd4;
    localparam logic [2:0] CAUSE_OVERFLOW  = 3'd5;
    localparam logic [2:0] CAUSE_SIGNATURE = 3'd6;
    localparam logic [2:0] CAUSE_TRUNCATED = 3'd7;

    // Header layout, in byte positions within one 60-byte header.
    localparam logic [5:0] NAME_LAST   = 6'd15;
    localparam logic [5:0] NAME_END    = 6'd16;
    localparam logic [5:0] SIZE_START  = 6'd48;
    localparam logic [5:0] SIZE_END    = 6'd58;
    localparam logic [5:0] SIG_FIRST   = 6'd58;
    localparam logic [5:0] SIG_SECOND  = 6'd59;

    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_BQUOTE  = 8'h60;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    // Largest size value that can still take one more decimal digit.
    localparam logic [31:0] SIZE_TENTH = 32'd429496729;
    // Images whose last byte sits at this offset or below are too short.
    localparam logic [31:0] SHORT_LAST_OFFSET = 32'd67;
    localparam logic [31:0] OFFSET_MAX = 32'hffff_ffff;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_cause;
        logic [15:0] file_index;
        logic [3:0]  name_length;
        logic [31:0] data_size;
        logic [31:0] data_offset;
        logic        end_of_archive;
    } result_t;

    // The results caused by one byte: count is 0, 1 or 2, first goes out first.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] value;
        case (idx)
            3'd0:    value = 8'h21;
            3'd1:    value = 8'h3c;
            3'd2:    value = 8'h61;
            3'd3:    value = 8'h72;
            3'd4:    value = 8'h63;
            3'd5:    value = 8'h68;
            3'd6:    value = 8'h3e;
            default: value = 8'h0a;
        endcase
        return value;
    endfunction

endpackage

>>> hdl/arhp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arhp_parse_core
// Parser state and the per-byte update; emits up to two results per byte.
// ----------------------------------------------------------------------------
module arhp_parse_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output arhp_pkg::result_pair_t results
);

    localparam logic [1:0] PH_MAGIC  = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_HALTED = 2'd3;

    logic [1:0]  phase_reg,  phase_next;
    logic [5:0]  fpos_reg,   fpos_next;
    logic [31:0] skip_reg,   skip_next;
    logic [31:0] acc_reg,    acc_next;
    logic [3:0]  slash_reg,  slash_next;
    logic        seen_reg,   seen_next;
    logic        ended_reg,  ended_next;
    logic [31:0] offset_reg, offset_next;
    logic [15:0] count_reg,  count_next;
    logic [2:0]  cause_reg,  cause_next;

    logic              hdr_done;
    logic              seen_now;
    logic [31:0]       skip_dec;
    logic [31:0]       acc_times_ten;
    logic [3:0]        digit;
    logic              is_short;
    arhp_pkg::result_t hdr_res;
    arhp_pkg::result_t end_res;

    always_comb begin
        phase_next  = phase_reg;
        fpos_next   = fpos_reg;
        skip_next   = skip_reg;
        acc_next    = acc_reg;
        slash_next  = slash_reg;
        seen_next   = seen_reg;
        ended_next  = ended_reg;
        count_next  = count_reg;
        cause_next  = cause_reg;
        hdr_done    = 1'b0;
        seen_now    = seen_reg || (data_byte == arhp_pkg::CHAR_SLASH);
        skip_dec    = skip_reg - 32'd1;
        digit       = data_byte[3:0];
        acc_times_ten = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                        + {28'd0, digit};
        offset_next = (offset_reg == arhp_pkg::OFFSET_MAX) ? offset_reg
                                                            : offset_reg + 32'd1;

        case (phase_reg)
            PH_MAGIC: begin
                if (data_byte != arhp_pkg::magic_byte(fpos_reg[2:0])) begin
                    phase_next = PH_HALTED;
                    cause_next = arhp_pkg::CAUSE_MAGIC;
                end else if (fpos_reg[2:0] == 3'd7) begin
                    phase_next = PH_HEADER;
                    fpos_next  = 6'd0;
                end else begin
                    fpos_next = fpos_reg + 6'd1;
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0) begin
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER: begin
                fpos_next = fpos_reg + 6'd1;
                if (fpos_reg < arhp_pkg::NAME_END) begin
                    if (!seen_reg && data_byte == arhp_pkg::CHAR_SLASH) begin
                        seen_next  = 1'b1;
                        slash_next = fpos_reg[3:0];
                    end
                    if (fpos_reg == arhp_pkg::NAME_LAST && !seen_now) begin
                        phase_next = PH_HALTED;
                        cause_next = arhp_pkg::CAUSE_NO_SLASH;
                        fpos_next  = fpos_reg;
                    end
                end else if (fpos_reg >= arhp_pkg::SIZE_START &&
                             fpos_reg < arhp_pkg::SIZE_END) begin
                    if (!ended_reg) begin
                        if (data_byte == arhp_pkg::CHAR_SPACE) begin
                            ended_next = 1'b1;
                        end else if (data_byte < arhp_pkg::CHAR_ZERO ||
                                     data_byte > arhp_pkg::CHAR_NINE) begin
                            phase_next = PH_HALTED;
                            cause_next = arhp_pkg::CAUSE_BAD_DIGIT;
                            fpos_next  = fpos_reg;
                        end else if (acc_reg > arhp_pkg::SIZE_TENTH ||
                                     (acc_reg == arhp_pkg::SIZE_TENTH &&
                                      digit > 4'd5)) begin
                            phase_next = PH_HALTED;
                            cause_next = arhp_pkg::CAUSE_OVERFLOW;
                            fpos_next  = fpos_reg;
                        end else begin
                            acc_next = acc_times_ten;
                        end
                    end
                end else if (fpos_reg == arhp_pkg::SIG_FIRST) begin
                    if (data_byte != arhp_pkg::CHAR_BQUOTE) begin
                        phase_next = PH_HALTED;
                        cause_next = arhp_pkg::CAUSE_SIGNATURE;
                        fpos_next  = fpos_reg;
                    end
                end else if (fpos_reg == arhp_pkg::SIG_SECOND) begin
                    if (data_byte != arhp_pkg::CHAR_NEWLINE) begin
                        phase_next = PH_HALTED;
                        cause_next = arhp_pkg::CAUSE_SIGNATURE;
                        fpos_next  = fpos_reg;
                    end else begin
                        hdr_done   = 1'b1;
                        count_next = count_reg + 16'd1;
                        skip_next  = acc_reg;
                        phase_next = (acc_reg != 32'd0) ? PH_SKIP : PH_HEADER;
                        fpos_next  = 6'd0;
                    end
                end
            end
            default: begin
            end
        endcase

        // A fresh header starts with clean field state.
        if (phase_next == PH_HEADER && fpos_next == 6'd0) begin
            acc_next   = 32'd0;
            slash_next = 4'd0;
            seen_next  = 1'b0;
            ended_next = 1'b0;
        end

        is_short = (offset_reg <= arhp_pkg::SHORT_LAST_OFFSET);

        hdr_res.kind           = arhp_pkg::KIND_HEADER;
        hdr_res.error_cause    = arhp_pkg::CAUSE_NONE;
        hdr_res.file_index     = count_reg;
        hdr_res.name_length    = slash_reg;
        hdr_res.data_size      = acc_reg;
        hdr_res.data_offset    = offset_next;
        hdr_res.end_of_archive = 1'b0;

        end_res.file_index     = count_next;
        end_res.name_length    = 4'd0;
        end_res.data_size      = 32'd0;
        end_res.data_offset    = 32'd0;
        end_res.end_of_archive = 1'b1;
        if (is_short) begin
            end_res.kind        = arhp_pkg::KIND_ERROR;
            end_res.error_cause = arhp_pkg::CAUSE_SHORT;
        end else if (phase_next == PH_HALTED) begin
            end_res.kind        = arhp_pkg::KIND_ERROR;
            end_res.error_cause = cause_next;
        end else if (phase_next == PH_HEADER && fpos_next != 6'd0) begin
            end_res.kind        = arhp_pkg::KIND_ERROR;
            end_res.error_cause = arhp_pkg::CAUSE_TRUNCATED;
        end else begin
            end_res.kind        = arhp_pkg::KIND_DONE;
            end_res.error_cause = arhp_pkg::CAUSE_NONE;
        end

        // A header finished on the last byte of a short image is dropped.
        results.second = end_res;
        if (hdr_done && !(last_byte && is_short)) begin
            results.first = hdr_res;
            results.count = last_byte ? 2'd2 : 2'd1;
        end else begin
            results.first = end_res;
            results.count = last_byte ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            phase_reg  <= PH_MAGIC;
            fpos_reg   <= 6'd0;
            skip_reg   <= 32'd0;
            acc_reg    <= 32'd0;
            slash_reg  <= 4'd0;
            seen_reg   <= 1'b0;
            ended_reg  <= 1'b0;
            offset_reg <= 32'd0;
            count_reg  <= 16'd0;
            cause_reg  <= arhp_pkg::CAUSE_NONE;
        end else if (step) begin
            phase_reg  <= phase_next;
            fpos_reg   <= fpos_next;
            skip_reg   <= skip_next;
            acc_reg    <= acc_next;
            slash_reg  <= slash_next;
            seen_reg   <= seen_next;
            ended_reg  <= ended_next;
            offset_reg <= offset_next;
            count_reg  <= count_next;
            cause_reg  <= cause_next;
        end
    end

endmodule

>>> hdl/arhp_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arhp_result_fifo
// Two-entry queue of result pairs, drained one result per output request.
// ----------------------------------------------------------------------------
module arhp_result_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  arhp_pkg::result_pair_t push_pair,
    output logic                   space,
    output logic                   m_valid,
    input  logic                   m_ready,
    output arhp_pkg::result_t      m_result
);

    arhp_pkg::result_pair_t entry_reg [2];
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic [1:0] fill_reg, fill_next;
    logic       sub_reg,  sub_next;
    logic       pop_item;
    logic       pop_entry;
    arhp_pkg::result_pair_t head_pair;

    always_comb begin
        head_pair = entry_reg[head_reg];
        m_valid   = (fill_reg != 2'd0);
        m_result  = sub_reg ? head_pair.second : head_pair.first;
        space     = (fill_reg != 2'd2);
        pop_item  = m_valid && m_ready;
        pop_entry = pop_item && (sub_reg || head_pair.count != 2'd2);

        head_next = pop_entry ? ~head_reg : head_reg;
        tail_next = push ? ~tail_reg : tail_reg;
        sub_next  = pop_entry ? 1'b0 : (pop_item ? 1'b1 : sub_reg);
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop_entry};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
            fill_reg <= 2'd0;
            sub_reg  <= 1'b0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            sub_reg  <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[tail_reg] <= push_pair;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3)
        else $error("result queue fill count out of range");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fill_reg != 2'd2))
        else $error("result pair pushed into a full queue");

    a_sub_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> (m_valid && head_pair.count == 2'd2))
        else $error("second result selected from an entry without one");

    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_pair.count != 2'd0))
        else $error("empty result pair pushed");

endmodule

>>> hdl/ar_archive_header_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ar_archive_header_parser_unit
// Streaming parser for unix ar archive images, one byte per cycle while the result queue has space.
// ----------------------------------------------------------------------------
// Usage:
// The image enters one byte per request on the s_ channel; s_tlast marks its
// final byte. The parser checks the "!<arch>\n" magic, then each 60-byte
// member header (slash in the name, decimal size, closing signature), and
// skips the member data. Each accepted header gives one result on the m_
// channel, but for one ending on the final byte of a short image; the final
// byte gives one end result (success or error cause), which carries m_tlast.
// The first format error stops parsing; bytes after it are consumed without
// effect until the final byte. A byte in the input register is parsed once the
// result queue has space; its results are registered in that queue before they
// show on m_tvalid. Throughput: one byte per cycle while the queue has space,
// set by the parse step between the input register and the result queue. A
// byte that ends a header and the image gives two results, which leave on two
// successive output requests. Reset (aresetn low, synchronous) empties the
// input register and the queue and returns the parser to the magic check.
// After the final byte it also returns to that state, ready for the next image.
// When the receiver stalls, results wait in a two-entry queue; once it is
// full, parsing pauses and s_tready falls while the input register holds a byte.
// ----------------------------------------------------------------------------
module ar_archive_header_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] error_cause, [18:3] file_index, [22:19] name_length,
    // [54:23] data_size, [86:55] data_offset, [87] zero fill
    output logic [87:0] m_tdata,
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // end_of_archive
);

    // Input register: holds one byte until the parser can take it.
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic                   consume;
    logic                   queue_space;
    arhp_pkg::result_pair_t pair;
    arhp_pkg::result_t      out_res;

    // The parser steps when a byte is held and the queue can take a pair.
    assign consume  = in_vld_reg && queue_space;
    assign s_tready = !in_vld_reg || consume;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (consume) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    arhp_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (consume),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .results   (pair)
    );

    // Only bytes that cause at least one result take a queue entry.
    arhp_result_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (consume && pair.count != 2'd0),
        .push_pair (pair),
        .space     (queue_space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (out_res)
    );

    assign m_tdata = {1'b0, out_res.data_offset, out_res.data_size,
                      out_res.name_length, out_res.file_index, out_res.error_cause};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.end_of_archive;

endmodule
